// ----- src/sdq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared types and constants for the shared-pool dual message queue.
// ----------------------------------------------------------------------------
package sdq_pkg;

	localparam int POOL_DEPTH_DEF = 32;
	localparam int CNT_W          = 6;
	localparam logic [CNT_W-1:0] MAX_MSG_RST = 6'd32;

	// operation codes on func
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef struct packed {
		logic [7:0]  msg_type;
		logic [7:0]  msg_size;
		logic [15:0] data_handle;
		logic [7:0]  data_tag;
	} payload_t;

	// write enables from the queue control to the node store
	typedef struct packed {
		logic pay;
		logic link;
	} mem_we_t;

	typedef struct packed {
		logic             status;
		payload_t         pay;
		logic [CNT_W-1:0] count;
	} result_t;

endpackage
`default_nettype wire

// ----- src/sdq_node_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdq_node_mem
// Node payload and link store, one read port with registered data and
// write-first forwarding of a same-cycle write.
// ----------------------------------------------------------------------------
module sdq_node_mem #(
	parameter int POOL_DEPTH = sdq_pkg::POOL_DEPTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire sdq_pkg::mem_we_t        we,
	input  wire [$clog2(POOL_DEPTH)-1:0] pay_waddr,
	input  wire sdq_pkg::payload_t       pay_wdata,
	input  wire [$clog2(POOL_DEPTH)-1:0] link_waddr,
	input  wire [$clog2(POOL_DEPTH)-1:0] link_wdata,
	input  wire [$clog2(POOL_DEPTH)-1:0] raddr,
	output sdq_pkg::payload_t            rd_pay,
	output logic [$clog2(POOL_DEPTH)-1:0] rd_link
);

	localparam int IDX_W = $clog2(POOL_DEPTH);

	sdq_pkg::payload_t pay_mem [POOL_DEPTH];
	logic [IDX_W-1:0]  link_mem [POOL_DEPTH];

	sdq_pkg::payload_t pay_rd_q, pay_byp_q;
	logic [IDX_W-1:0]  link_rd_q, link_byp_q;
	logic              pay_hit_q, link_hit_q;

	always_ff @(posedge clk) begin
		if (we.pay) begin
			pay_mem[pay_waddr] <= pay_wdata;
		end
		if (we.link) begin
			link_mem[link_waddr] <= link_wdata;
		end
		pay_rd_q   <= pay_mem[raddr];
		link_rd_q  <= link_mem[raddr];
		pay_byp_q  <= pay_wdata;
		link_byp_q <= link_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_hit_q  <= 1'b0;
			link_hit_q <= 1'b0;
		end else begin
			pay_hit_q  <= we.pay && (pay_waddr == raddr);
			link_hit_q <= we.link && (link_waddr == raddr);
		end
	end

	assign rd_pay  = pay_hit_q ? pay_byp_q : pay_rd_q;
	assign rd_link = link_hit_q ? link_byp_q : link_rd_q;

endmodule
`default_nettype wire

// ----- src/sdq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdq_ctrl
// Queue heads, tails, free map and held count; executes one push or pop
// per cycle and forms its result.
// ----------------------------------------------------------------------------
module sdq_ctrl #(
	parameter int POOL_DEPTH = sdq_pkg::POOL_DEPTH_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  valid_s1,
	input  wire                                  func_s1,
	input  wire                                  sel_s1,
	input  wire [sdq_pkg::CNT_W-1:0]             max_msg,
	input  wire sdq_pkg::payload_t               rd_pay,
	input  wire [$clog2(POOL_DEPTH)-1:0]         rd_link,
	output logic [1:0][$clog2(POOL_DEPTH)-1:0]   head_nx,
	output sdq_pkg::mem_we_t                     we,
	output logic [$clog2(POOL_DEPTH)-1:0]        pay_waddr,
	output logic [$clog2(POOL_DEPTH)-1:0]        link_waddr,
	output logic [$clog2(POOL_DEPTH)-1:0]        link_wdata,
	output sdq_pkg::result_t                     res
);

	localparam int IDX_W = $clog2(POOL_DEPTH);

	logic [1:0][IDX_W-1:0]         head_q, tail_q, tail_d;
	logic [1:0]                    ne_q, ne_d;
	logic [POOL_DEPTH-1:0]         free_q, free_d;
	logic [sdq_pkg::CNT_W-1:0]     cnt_q, cnt_d;
	logic [IDX_W-1:0]              n_free, h;
	logic                          push_ok, pop_ok;

	// lowest free node
	always_comb begin
		n_free = '0;
		for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				n_free = IDX_W'(i);
			end
		end
	end

	assign h       = head_q[sel_s1];
	assign push_ok = valid_s1 && (func_s1 == sdq_pkg::FUNC_PUSH)
		&& (cnt_q < max_msg) && (|free_q);
	assign pop_ok  = valid_s1 && (func_s1 == sdq_pkg::FUNC_POP) && ne_q[sel_s1];

	always_comb begin
		head_nx    = head_q;
		tail_d     = tail_q;
		ne_d       = ne_q;
		free_d     = free_q;
		cnt_d      = cnt_q;
		we         = '0;
		pay_waddr  = n_free;
		link_waddr = tail_q[sel_s1];
		link_wdata = n_free;
		if (push_ok) begin
			we.pay         = 1'b1;
			free_d[n_free] = 1'b0;
			if (ne_q[sel_s1]) begin
				we.link = 1'b1;
			end else begin
				head_nx[sel_s1] = n_free;
				ne_d[sel_s1]    = 1'b1;
			end
			tail_d[sel_s1] = n_free;
			cnt_d          = cnt_q + 1'b1;
		end else if (pop_ok) begin
			if (h == tail_q[sel_s1]) begin
				ne_d[sel_s1] = 1'b0;
			end else begin
				head_nx[sel_s1] = rd_link;
			end
			free_d[h] = 1'b1;
			if (cnt_q != '0) begin
				cnt_d = cnt_q - 1'b1;
			end
		end
		res.status = !(push_ok || pop_ok);
		res.pay    = pop_ok ? rd_pay : '0;
		res.count  = cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			ne_q   <= '0;
			free_q <= '1;
			cnt_q  <= '0;
		end else begin
			head_q <= head_nx;
			tail_q <= tail_d;
			ne_q   <= ne_d;
			free_q <= free_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule
`default_nettype wire

// ----- src/shared_pool_dual_fifo_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// shared_pool_dual_fifo_queue
// Incoming and outgoing message queues kept as linked lists in one shared
// node pool, with a limit on the total number of held messages.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------------------
//  command   start / busy            func, queue_select, msg_type, msg_size,
//                                    data_handle, data_tag
//  result    done (one-cycle strobe) status, out_type, out_size, out_handle,
//                                    out_tag, total_count
//  config    cfg_valid / cfg_ready   cfg_data (max_messages)
//
//  One command is taken per cycle while busy is low. Its result strobes on done
//  after the transfer passes the input register, while the node store reads the
//  head node, and then the result register. The whole push or pop (free node
//  search, link update, count) is combinational logic between those registers.
//  busy and cfg_ready hold off transfers during reset and until rdy_q is set.
//  No clearing pass: the node store is not reset. Results cannot be stalled.
//
module shared_pool_dual_fifo_queue #(
	parameter int POOL_DEPTH = sdq_pkg::POOL_DEPTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	// command
	input  wire                             start,
	output logic                            busy,
	input  wire                             func,
	input  wire                             queue_select,
	input  wire [7:0]                       msg_type,
	input  wire [7:0]                       msg_size,
	input  wire [15:0]                      data_handle,
	input  wire [7:0]                       data_tag,
	// result
	output logic                            done,
	output logic                            status,
	output logic [7:0]                      out_type,
	output logic [7:0]                      out_size,
	output logic [15:0]                     out_handle,
	output logic [7:0]                      out_tag,
	output logic [sdq_pkg::CNT_W-1:0]       total_count,
	// configuration
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [sdq_pkg::CNT_W-1:0]        cfg_data
);

	localparam int IDX_W = $clog2(POOL_DEPTH);

	logic                        rdy_q;
	logic                        accept;
	logic [sdq_pkg::CNT_W-1:0]   max_q;

	logic                        valid_s1, func_s1, sel_s1;
	sdq_pkg::payload_t           pay_s1;

	logic [1:0][IDX_W-1:0]       head_nx;
	sdq_pkg::mem_we_t            we;
	logic [IDX_W-1:0]            pay_waddr, link_waddr, link_wdata, rd_link;
	sdq_pkg::payload_t           rd_pay;
	sdq_pkg::result_t            res_d, res_q;
	logic                        done_q;

	// hold off both channels until the first cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_q <= 1'b0;
		end else begin
			rdy_q <= 1'b1;
		end
	end

	assign busy      = !rdy_q;
	assign cfg_ready = rdy_q;
	assign accept    = start && rdy_q;

	// message limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= sdq_pkg::MAX_MSG_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_q <= cfg_data;
		end
	end

	// input register: capture the command on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1            <= func;
			sel_s1             <= queue_select;
			pay_s1.msg_type    <= msg_type;
			pay_s1.msg_size    <= msg_size;
			pay_s1.data_handle <= data_handle;
			pay_s1.data_tag    <= data_tag;
		end
	end

	// Read the head of the addressed queue as it stands after the command now
	// in the input register; the store forwards that command's own writes.
	sdq_node_mem #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.we         (we),
		.pay_waddr  (pay_waddr),
		.pay_wdata  (pay_s1),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.raddr      (head_nx[queue_select]),
		.rd_pay     (rd_pay),
		.rd_link    (rd_link)
	);

	sdq_ctrl #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.func_s1    (func_s1),
		.sel_s1     (sel_s1),
		.max_msg    (max_q),
		.rd_pay     (rd_pay),
		.rd_link    (rd_link),
		.head_nx    (head_nx),
		.we         (we),
		.pay_waddr  (pay_waddr),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.res        (res_d)
	);

	// result register: strobe for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q <= res_d;
		end
	end

	assign done        = done_q;
	assign status      = res_q.status;
	assign out_type    = res_q.pay.msg_type;
	assign out_size    = res_q.pay.msg_size;
	assign out_handle  = res_q.pay.data_handle;
	assign out_tag     = res_q.pay.data_tag;
	assign total_count = res_q.count;

endmodule
`default_nettype wire

// ----- src/sdq_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdq_checker
// Port-level checks for the shared-pool dual message queue.
// ----------------------------------------------------------------------------
module sdq_checker #(
	parameter int POOL_DEPTH = sdq_pkg::POOL_DEPTH_DEF
) (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       start,
	input wire                       busy,
	input wire                       done,
	input wire                       status,
	input wire [7:0]                 out_type,
	input wire [7:0]                 out_size,
	input wire [15:0]                out_handle,
	input wire [7:0]                 out_tag,
	input wire [sdq_pkg::CNT_W-1:0]  total_count
);

	// every transfer is followed by a result on done
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("no result two cycles after a command transfer");

	// no result without an earlier transfer
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a command transfer");

	// a failed operation carries no message
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (out_type == 8'd0 && out_size == 8'd0
			&& out_handle == 16'd0 && out_tag == 8'd0))
		else $error("failed operation returned message data");

	// the held count moves by at most one between back-to-back results
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done)) |-> (total_count == $past(total_count)
			|| total_count == $past(total_count) + 6'd1
			|| total_count == $past(total_count) - 6'd1))
		else $error("held count jumped by more than one");

	// never more messages than pool nodes
	a_count_pool: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (int'(total_count) <= POOL_DEPTH))
		else $error("held count exceeds the pool depth");

endmodule

bind shared_pool_dual_fifo_queue sdq_checker #(
	.POOL_DEPTH (POOL_DEPTH)
) u_sdq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.out_type    (out_type),
	.out_size    (out_size),
	.out_handle  (out_handle),
	.out_tag     (out_tag),
	.total_count (total_count)
);
`default_nettype wire
